// ----- design/jads_pkg.sv -----
// shared types and constants of the joystick axis dead-zone scaler
`default_nettype none

package jads_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER     = 3'd0,
    REG_RANGE_LOW  = 3'd1,
    REG_RANGE_HIGH = 3'd2,
    REG_DEAD_WIDTH = 3'd3,
    REG_INVERT     = 3'd4
  } reg_idx_e;

  // fixed result field widths
  localparam int unsigned RAW_ECHO_W = 10;
  localparam int unsigned POS_W      = 11;

  localparam int unsigned DEAD_RESET = 32;

  // per-item classification carried from front to back
  typedef struct packed {
    logic status;    // calibration invalid
    logic neg_side;  // below the lower dead-zone edge
    logic in_dead;
    logic at_limit;
    logic invert;
  } flags_t;

endpackage

`default_nettype wire

// ----- design/jads_front.sv -----
// front stage: takes a sample, checks calibration, clamps and works out distance and span
`default_nettype none

module jads_front #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   hold_i,
  input  wire logic [SAMPLE_BITS-1:0] center_i,
  input  wire logic [SAMPLE_BITS-1:0] range_low_i,
  input  wire logic [SAMPLE_BITS-1:0] range_high_i,
  input  wire logic [SAMPLE_BITS-1:0] dead_width_i,
  input  wire logic                   invert_i,
  output logic                        valid_o,
  output jads_pkg::flags_t            flags_o,
  output logic [SAMPLE_BITS-1:0]      raw_o,
  output logic [SAMPLE_BITS-1:0]      dist_o,
  output logic [SAMPLE_BITS-1:0]      span_o
);

  localparam int unsigned EW = SAMPLE_BITS + 1;

  logic                   valid_q, valid_d;
  logic                   load;
  jads_pkg::flags_t       flags_q, flags_d;
  logic [SAMPLE_BITS-1:0] raw_q, dist_q, span_q, dist_d, span_d;

  logic [EW-1:0] c_w, rl_w, rh_w, dw_w, raw_w, lower_w, upper_w, clamp_w;
  logic [EW-1:0] dist_w, span_w;
  logic          cal_ok, below, above;

  always_comb begin
    c_w   = {1'b0, center_i};
    rl_w  = {1'b0, range_low_i};
    rh_w  = {1'b0, range_high_i};
    dw_w  = {1'b0, dead_width_i};
    raw_w = {1'b0, sample_i};

    lower_w = c_w - dw_w;
    upper_w = c_w + dw_w;
    cal_ok  = (rl_w < rh_w) && (c_w > rl_w) && (c_w < rh_w) && (dw_w <= c_w)
              && (lower_w > rl_w) && (upper_w < rh_w);

    if (raw_w < rl_w) begin
      clamp_w = rl_w;
    end else if (raw_w > rh_w) begin
      clamp_w = rh_w;
    end else begin
      clamp_w = raw_w;
    end

    below = cal_ok && (clamp_w < lower_w);
    above = cal_ok && !below && (clamp_w > upper_w);

    // dead zone and bad calibration divide zero by one
    dist_w = EW'(0);
    span_w = EW'(1);
    if (below) begin
      dist_w = lower_w - clamp_w;
      span_w = lower_w - rl_w;
    end else if (above) begin
      dist_w = clamp_w - upper_w;
      span_w = rh_w - upper_w;
    end
    dist_d = dist_w[SAMPLE_BITS-1:0];
    span_d = span_w[SAMPLE_BITS-1:0];

    flags_d.status   = !cal_ok;
    flags_d.neg_side = below;
    flags_d.in_dead  = cal_ok && (raw_w >= lower_w) && (raw_w <= upper_w);
    flags_d.at_limit = cal_ok && ((raw_w <= rl_w) || (raw_w >= rh_w));
    flags_d.invert   = invert_i;
  end

  assign load    = !(valid_q && hold_i);
  assign valid_d = load ? take_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && take_i) begin
      flags_q <= flags_d;
      raw_q   <= sample_i;
      dist_q  <= dist_d;
      span_q  <= span_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign raw_o   = raw_q;
  assign dist_o  = dist_q;
  assign span_o  = span_q;

endmodule

`default_nettype wire

// ----- design/jads_queue.sv -----
// two-entry item queue between the front and the back
`default_nettype none

module jads_queue #(
  parameter int unsigned WIDTH = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/jads_back.sv -----
// back stage: scale multiply, pipelined restoring divider, sign and result register
`default_nettype none

module jads_back #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned FULL_SCALE  = 1000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire jads_pkg::flags_t                flags_i,
  input  wire logic [SAMPLE_BITS-1:0]          raw_i,
  input  wire logic [SAMPLE_BITS-1:0]          dist_i,
  input  wire logic [SAMPLE_BITS-1:0]          span_i,
  output logic                                 valid_o,
  output logic [jads_pkg::RAW_ECHO_W-1:0]      raw_echo_o,
  output logic signed [jads_pkg::POS_W-1:0]    position_o,
  output logic                                 in_dead_zone_o,
  output logic                                 at_limit_o,
  output logic                                 status_o
);

  // quotient never exceeds FULL_SCALE since dist <= span
  localparam int unsigned QW  = $clog2(FULL_SCALE + 1);
  localparam int unsigned NW  = SAMPLE_BITS + QW;
  localparam int unsigned NST = QW + 1;

  logic                   vld_q  [NST];
  logic [NW-1:0]          acc_q  [NST];
  logic [SAMPLE_BITS-1:0] span_q [NST];
  logic [SAMPLE_BITS-1:0] raw_q  [NST];
  jads_pkg::flags_t       flg_q  [NST];

  logic                               out_valid_q;
  logic [jads_pkg::RAW_ECHO_W-1:0]    out_raw_q;
  logic [jads_pkg::POS_W-1:0]         out_pos_q, out_pos_d;
  jads_pkg::flags_t                   out_flg_q;

  logic [31:0] quo_w, signed_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[NST-1];
    end
  end

  // numerator: upper bits start as the partial remainder, lower bits shift in
  always_ff @(posedge clk_i) begin
    acc_q[0]  <= NW'(dist_i) * NW'(FULL_SCALE);
    span_q[0] <= span_i;
    raw_q[0]  <= raw_i;
    flg_q[0]  <= flags_i;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [SAMPLE_BITS:0] trial;
    logic [SAMPLE_BITS:0] rem;
    logic [QW:0]          low;
    logic                 ge;

    always_comb begin
      trial = {acc_q[k][NW-1:QW], acc_q[k][QW-1]};
      ge    = trial >= {1'b0, span_q[k]};
      rem   = ge ? trial - {1'b0, span_q[k]} : trial;
      low   = {acc_q[k][QW-1:0], ge};
    end

    always_ff @(posedge clk_i) begin
      acc_q[k+1]  <= {rem[SAMPLE_BITS-1:0], low[QW-1:0]};
      span_q[k+1] <= span_q[k];
      raw_q[k+1]  <= raw_q[k];
      flg_q[k+1]  <= flg_q[k];
    end
  end

  always_comb begin
    quo_w    = 32'(acc_q[NST-1][QW-1:0]);
    signed_w = (flg_q[NST-1].neg_side ^ flg_q[NST-1].invert) ? (32'd0 - quo_w) : quo_w;
    out_pos_d = signed_w[jads_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    out_raw_q <= jads_pkg::RAW_ECHO_W'(raw_q[NST-1]);
    out_pos_q <= out_pos_d;
    out_flg_q <= flg_q[NST-1];
  end

  assign valid_o        = out_valid_q;
  assign raw_echo_o     = out_raw_q;
  assign position_o     = out_pos_q;
  assign in_dead_zone_o = out_flg_q.in_dead;
  assign at_limit_o     = out_flg_q.at_limit;
  assign status_o       = out_flg_q.status;

endmodule

`default_nettype wire

// ----- design/joystick_axis_deadzone_scaler_unit.sv -----
// top level of the joystick axis dead-zone scaler: configuration registers and stage wiring
//
// Usage:
//   Raise start for a cycle with a converter reading on sample_i; the item is
//   taken at the clock edge where start is high and busy is low. busy stays low
//   in normal running, so one sample can be taken every cycle.
//   Each item yields exactly one result, shown for one cycle with
//   result_valid_o high: raw echo, signed position, dead-zone and limit flags
//   and status (1 when the calibration registers are inconsistent).
//   From acceptance the item passes a front register, the item queue, the
//   scaling multiply, one divider stage per quotient bit and the result
//   register. Throughput is one item per cycle, set by the divider pipeline
//   which retires one item every cycle.
//   The receiver cannot stall; results are taken in the cycle they appear.
//   Calibration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the
//   user must write it only while no item is in flight, which the block
//   itself does not enforce. Reset restores the register defaults (centre at
//   mid scale, full range, dead width 32, no inversion) and drops items in flight.
`default_nettype none

module joystick_axis_deadzone_scaler_unit #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned FULL_SCALE  = 1000
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [SAMPLE_BITS-1:0]            sample_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [jads_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [SAMPLE_BITS-1:0]            cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic [jads_pkg::RAW_ECHO_W-1:0]        raw_echo_o,
  output logic signed [jads_pkg::POS_W-1:0]      position_o,
  output logic                                   in_dead_zone_o,
  output logic                                   at_limit_o,
  output logic                                   status_o
);

  localparam int unsigned FLG_W  = $bits(jads_pkg::flags_t);
  localparam int unsigned ITEM_W = FLG_W + 3 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] center_q, range_low_q, range_high_q, dead_width_q;
  logic                   invert_q;

  logic                   accept;
  logic                   f_valid;
  jads_pkg::flags_t       f_flags, q_flags;
  logic [SAMPLE_BITS-1:0] f_raw, f_dist, f_span, q_raw, q_dist, q_span;
  logic [ITEM_W-1:0]      q_wdata, q_rdata;
  logic                   q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q     <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
      range_low_q  <= '0;
      range_high_q <= '1;
      dead_width_q <= SAMPLE_BITS'(jads_pkg::DEAD_RESET);
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jads_pkg::REG_CENTER:     center_q     <= cfg_wdata_i;
        jads_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        jads_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        jads_pkg::REG_DEAD_WIDTH: dead_width_q <= cfg_wdata_i;
        jads_pkg::REG_INVERT:     invert_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front holds only when its register is full and the queue cannot take it
  assign busy   = f_valid && q_full;
  assign accept = start && !busy;

  jads_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept),
    .sample_i    (sample_i),
    .hold_i      (q_full),
    .center_i    (center_q),
    .range_low_i (range_low_q),
    .range_high_i(range_high_q),
    .dead_width_i(dead_width_q),
    .invert_i    (invert_q),
    .valid_o     (f_valid),
    .flags_o     (f_flags),
    .raw_o       (f_raw),
    .dist_o      (f_dist),
    .span_o      (f_span)
  );

  assign q_wdata = {f_flags, f_raw, f_dist, f_span};

  jads_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .wdata_i(q_wdata),
    .pop_i  (!q_empty),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign q_flags = jads_pkg::flags_t'(q_rdata[ITEM_W-1 -: FLG_W]);
  assign q_raw   = q_rdata[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign q_dist  = q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign q_span  = q_rdata[SAMPLE_BITS-1:0];

  jads_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FULL_SCALE (FULL_SCALE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_empty),
    .flags_i       (q_flags),
    .raw_i         (q_raw),
    .dist_i        (q_dist),
    .span_i        (q_span),
    .valid_o       (result_valid_o),
    .raw_echo_o    (raw_echo_o),
    .position_o    (position_o),
    .in_dead_zone_o(in_dead_zone_o),
    .at_limit_o    (at_limit_o),
    .status_o      (status_o)
  );

`ifndef SYNTHESIS
  // the back drains one item a cycle, so the queue never backs up
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("queue backed up into the front");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> position_o == '0 && !in_dead_zone_o && !at_limit_o)
    else $error("bad calibration item carries a position or flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && in_dead_zone_o |-> position_o == '0)
    else $error("dead-zone item has a non-zero position");
`endif

endmodule

`default_nettype wire
